// ===== sv/advection_diffusion_stencil_macros.svh =====
// Assertion macros for the advection/diffusion stencil pipeline.
// Depends on nothing; included by the top-level module, which carries the assertions.
`ifndef ADVECTION_DIFFUSION_STENCIL_MACROS_SVH
`define ADVECTION_DIFFUSION_STENCIL_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define ADST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define ADST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> (cons)) \
    else $error(msg);
`else
`define ADST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ADST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/adst_pkg.sv =====
// Shared types, constants and fixed-point helpers of the stencil pipeline.
// No dependencies.
package adst_pkg;

  localparam int FracBits = 16;

  // Register reset value: 1.0 in Q16.16
  localparam logic [30:0] CfgReset = 31'd65536;

  typedef enum logic [2:0] {
    CfgViscosity = 3'd0,
    CfgInvDxX    = 3'd1,
    CfgInvDxY    = 3'd2,
    CfgInvDxXSq  = 3'd3,
    CfgInvDxYSq  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] viscosity;
    logic [30:0] inv_dx_x;
    logic [30:0] inv_dx_y;
    logic [30:0] inv_dx_x_sq;
    logic [30:0] inv_dx_y_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] u_center;
    logic signed [31:0] u_east;
    logic signed [31:0] u_west;
    logic signed [31:0] u_north;
    logic signed [31:0] u_south;
    logic signed [31:0] v_center;
    logic signed [31:0] v_east;
    logic signed [31:0] v_west;
    logic signed [31:0] v_north;
    logic signed [31:0] v_south;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rhs_x;
    logic signed [31:0] rhs_y;
  } out_item_t;

  // Face averages and saturated second differences
  typedef struct packed {
    logic signed [31:0] fue;
    logic signed [31:0] fuw;
    logic signed [31:0] fun;
    logic signed [31:0] fus;
    logic signed [31:0] fve;
    logic signed [31:0] fvw;
    logic signed [31:0] fvn;
    logic signed [31:0] fvs;
    logic signed [31:0] sdu_x;
    logic signed [31:0] sdu_y;
    logic signed [31:0] sdv_x;
    logic signed [31:0] sdv_y;
  } prep_t;

  // Raw full products of the first multiplier rank
  typedef struct packed {
    logic signed [63:0] ue2;
    logic signed [63:0] uw2;
    logic signed [63:0] unvn;
    logic signed [63:0] usvs;
    logic signed [63:0] vn2;
    logic signed [63:0] vs2;
    logic signed [63:0] ueve;
    logic signed [63:0] uwvw;
    logic signed [63:0] dux;
    logic signed [63:0] duy;
    logic signed [63:0] dvx;
    logic signed [63:0] dvy;
  } prod_t;

  // Saturated intermediate terms
  typedef struct packed {
    logic signed [31:0] adv_x;
    logic signed [31:0] cross_x;
    logic signed [31:0] diff_x;
    logic signed [31:0] adv_y;
    logic signed [31:0] cross_y;
    logic signed [31:0] diff_y;
  } term_t;

  // Raw full products of the second multiplier rank
  typedef struct packed {
    logic signed [63:0] adv_x;
    logic signed [63:0] cross_x;
    logic signed [63:0] visc_x;
    logic signed [63:0] adv_y;
    logic signed [63:0] cross_y;
    logic signed [63:0] visc_y;
  } scal_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    if (x > 34'sd2147483647) begin
      sat34 = 32'sh7fffffff;
    end else if (x < -34'sd2147483648) begin
      sat34 = 32'sh80000000;
    end else begin
      sat34 = x[31:0];
    end
  endfunction

  // Drop fraction bits (floor), then clamp to 32 bits
  function automatic logic signed [31:0] fmul_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FracBits;
    if (s > 64'sd2147483647) begin
      fmul_sat = 32'sh7fffffff;
    end else if (s < -64'sd2147483648) begin
      fmul_sat = 32'sh80000000;
    end else begin
      fmul_sat = s[31:0];
    end
  endfunction

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = a;
    bx = b;
    mul32 = ax * bx;
  endfunction

  function automatic logic signed [31:0] cfg_s(input logic [30:0] r);
    cfg_s = {1'b0, r};
  endfunction

  function automatic logic signed [33:0] ext34(input logic signed [31:0] a);
    ext34 = {{2{a[31]}}, a};
  endfunction

  // Floor of (a + b) / 2
  function automatic logic signed [31:0] avg2(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    avg2 = s[32:1];
  endfunction

  // a - 2c + b, clamped
  function automatic logic signed [31:0] sec_diff(input logic signed [31:0] a,
                                                 input logic signed [31:0] c,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = ext34(a) - {c[31], c, 1'b0} + ext34(b);
    sec_diff = sat34(s);
  endfunction

endpackage

// ===== sv/adst_prep.sv =====
// Stage 1: face averages and second differences of the stencil.
// Depends on adst_pkg.
module adst_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  adst_pkg::in_item_t item_i,
  output logic             valid_o,
  input  logic             ready_i,
  output adst_pkg::prep_t  data_o
);

  logic            valid_q;
  adst_pkg::prep_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.fue   = adst_pkg::avg2(item_i.u_east, item_i.u_center);
    data_d.fuw   = adst_pkg::avg2(item_i.u_center, item_i.u_west);
    data_d.fun   = adst_pkg::avg2(item_i.u_north, item_i.u_center);
    data_d.fus   = adst_pkg::avg2(item_i.u_center, item_i.u_south);
    data_d.fve   = adst_pkg::avg2(item_i.v_east, item_i.v_center);
    data_d.fvw   = adst_pkg::avg2(item_i.v_center, item_i.v_west);
    data_d.fvn   = adst_pkg::avg2(item_i.v_north, item_i.v_center);
    data_d.fvs   = adst_pkg::avg2(item_i.v_center, item_i.v_south);
    data_d.sdu_x = adst_pkg::sec_diff(item_i.u_east, item_i.u_center, item_i.u_west);
    data_d.sdu_y = adst_pkg::sec_diff(item_i.u_north, item_i.u_center, item_i.u_south);
    data_d.sdv_x = adst_pkg::sec_diff(item_i.v_east, item_i.v_center, item_i.v_west);
    data_d.sdv_y = adst_pkg::sec_diff(item_i.v_north, item_i.v_center, item_i.v_south);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/adst_mul1.sv =====
// Stage 2: first multiplier rank (face products, diffusion scaling).
// Depends on adst_pkg.
module adst_mul1 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  adst_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  adst_pkg::prep_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output adst_pkg::prod_t data_o
);

  logic                  valid_q;
  adst_pkg::prod_t       data_d, data_q;
  logic signed [31:0]    inv_xx, inv_yy;

  assign ready_o = !valid_q || ready_i;
  assign inv_xx  = adst_pkg::cfg_s(cfg_i.inv_dx_x_sq);
  assign inv_yy  = adst_pkg::cfg_s(cfg_i.inv_dx_y_sq);

  always_comb begin
    data_d.ue2  = adst_pkg::mul32(data_i.fue, data_i.fue);
    data_d.uw2  = adst_pkg::mul32(data_i.fuw, data_i.fuw);
    data_d.unvn = adst_pkg::mul32(data_i.fun, data_i.fvn);
    data_d.usvs = adst_pkg::mul32(data_i.fus, data_i.fvs);
    data_d.vn2  = adst_pkg::mul32(data_i.fvn, data_i.fvn);
    data_d.vs2  = adst_pkg::mul32(data_i.fvs, data_i.fvs);
    data_d.ueve = adst_pkg::mul32(data_i.fue, data_i.fve);
    data_d.uwvw = adst_pkg::mul32(data_i.fuw, data_i.fvw);
    data_d.dux  = adst_pkg::mul32(data_i.sdu_x, inv_xx);
    data_d.duy  = adst_pkg::mul32(data_i.sdu_y, inv_yy);
    data_d.dvx  = adst_pkg::mul32(data_i.sdv_x, inv_xx);
    data_d.dvy  = adst_pkg::mul32(data_i.sdv_y, inv_yy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/adst_reduce.sv =====
// Stage 3: rescale products, form saturated differences and diffusion sums.
// Depends on adst_pkg.
module adst_reduce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  adst_pkg::prod_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output adst_pkg::term_t data_o
);

  logic            valid_q;
  adst_pkg::term_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.adv_x   = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.ue2))
                                     - adst_pkg::ext34(adst_pkg::fmul_sat(data_i.uw2)));
    data_d.cross_x = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.unvn))
                                     - adst_pkg::ext34(adst_pkg::fmul_sat(data_i.usvs)));
    data_d.diff_x  = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.dux))
                                     + adst_pkg::ext34(adst_pkg::fmul_sat(data_i.duy)));
    data_d.adv_y   = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.vn2))
                                     - adst_pkg::ext34(adst_pkg::fmul_sat(data_i.vs2)));
    data_d.cross_y = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.ueve))
                                     - adst_pkg::ext34(adst_pkg::fmul_sat(data_i.uwvw)));
    data_d.diff_y  = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(data_i.dvx))
                                     + adst_pkg::ext34(adst_pkg::fmul_sat(data_i.dvy)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/adst_post.sv =====
// Stages 4 and 5: second multiplier rank, then the final saturated sum.
// Depends on adst_pkg.
module adst_post (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adst_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  adst_pkg::term_t     data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output adst_pkg::out_item_t item_o
);

  logic                valid_s4_q, valid_s5_q;
  logic                ready_s5;
  adst_pkg::scal_t     scal_d, scal_q;
  adst_pkg::out_item_t res_d, res_q;
  logic signed [31:0]  nu, inv_x, inv_y;

  assign ready_s5 = !valid_s5_q || ready_i;
  assign ready_o  = !valid_s4_q || ready_s5;

  assign nu    = adst_pkg::cfg_s(cfg_i.viscosity);
  assign inv_x = adst_pkg::cfg_s(cfg_i.inv_dx_x);
  assign inv_y = adst_pkg::cfg_s(cfg_i.inv_dx_y);

  always_comb begin
    scal_d.adv_x   = adst_pkg::mul32(data_i.adv_x, inv_x);
    scal_d.cross_x = adst_pkg::mul32(data_i.cross_x, inv_y);
    scal_d.visc_x  = adst_pkg::mul32(nu, data_i.diff_x);
    scal_d.adv_y   = adst_pkg::mul32(data_i.adv_y, inv_y);
    scal_d.cross_y = adst_pkg::mul32(data_i.cross_y, inv_x);
    scal_d.visc_y  = adst_pkg::mul32(nu, data_i.diff_y);
  end

  // visc - adv - cross, all three already clamped to 32 bits
  always_comb begin
    res_d.rhs_x = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.visc_x))
                                  - adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.adv_x))
                                  - adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.cross_x)));
    res_d.rhs_y = adst_pkg::sat34(adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.visc_y))
                                  - adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.adv_y))
                                  - adst_pkg::ext34(adst_pkg::fmul_sat(scal_q.cross_y)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s4_q <= 1'b0;
      valid_s5_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_s4_q <= valid_i;
      end
      if (ready_s5) begin
        valid_s5_q <= valid_s4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      scal_q <= scal_d;
    end
    if (ready_s5 && valid_s4_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_s5_q;
  assign item_o  = res_q;

endmodule

// ===== sv/advection_diffusion_stencil.sv =====
// Advection/diffusion stencil: explicit momentum right-hand sides per cell.
// Path: prep, mul1, reduce, stage-4 and stage-5 registers lie between input and result.
// Throughput: one item per clock unstalled, set by the two fully pipelined multiplier ranks.
// Back-pressure stalls only the stages that hold items; bubbles are squeezed out.
// Reset (rst_ni low, async): pipeline emptied, config registers back to 1.0 (Q16.16).
// Uses adst_pkg, adst_prep, adst_mul1, adst_reduce, adst_post and the macro header.
`include "advection_diffusion_stencil_macros.svh"

module advection_diffusion_stencil (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [30:0]         cfg_wdata_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adst_pkg::in_item_t  in_item_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adst_pkg::out_item_t out_item_o
);

  // Configuration registers. The user must write them only while the pipeline is empty
  // (the block does not enforce it), so the stages read them directly without per-item copies.
  adst_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (adst_pkg::cfg_idx_e'(cfg_idx_i))
        adst_pkg::CfgViscosity: cfg_d.viscosity   = cfg_wdata_i;
        adst_pkg::CfgInvDxX:    cfg_d.inv_dx_x    = cfg_wdata_i;
        adst_pkg::CfgInvDxY:    cfg_d.inv_dx_y    = cfg_wdata_i;
        adst_pkg::CfgInvDxXSq:  cfg_d.inv_dx_x_sq = cfg_wdata_i;
        adst_pkg::CfgInvDxYSq:  cfg_d.inv_dx_y_sq = cfg_wdata_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{default: adst_pkg::CfgReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline: each stage holds an item with its own valid bit and reports
  // ready when empty or when its successor takes its item this cycle.
  logic            prep_valid, prep_ready;
  logic            mul_valid, mul_ready;
  logic            red_valid, red_ready;
  adst_pkg::prep_t prep_data;
  adst_pkg::prod_t mul_data;
  adst_pkg::term_t red_data;

  // Stage 1: face averages, second differences
  adst_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .data_o  (prep_data)
  );

  // Stage 2: eight face products, four diffusion scalings
  adst_mul1 u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .data_o  (mul_data)
  );

  // Stage 3: rescale, saturated differences and sums
  adst_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (red_valid),
    .ready_i (red_ready),
    .data_o  (red_data)
  );

  // Stages 4-5: spacing/viscosity scaling, final sum into output register
  adst_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (red_valid),
    .ready_o (red_ready),
    .data_i  (red_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

  // A ready sink keeps the whole pipeline open.
  `ADST_ASSERT_IMP(a_sink_ready_opens, clk_i, rst_ni, out_ready_i, in_ready_o,
                   "input blocked while sink ready")
  // Input refused only when the output holds a stalled item (pipeline full).
  `ADST_ASSERT_IMP(a_refuse_only_full, clk_i, rst_ni, !in_ready_o,
                   out_valid_o && !out_ready_i, "input refused with room left")
  // Without back-pressure an accepted item shows up at the output.
  `ADST_ASSERT_NXT(a_latency_five, clk_i, rst_ni,
                   (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i
                     ##1 out_ready_i ##1 out_ready_i,
                   out_valid_o, "item lost in pipeline")

endmodule

// ===== tb/advection_diffusion_stencil_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for advection_diffusion_stencil: random and directed cells,
// bit-exact rhs prediction, valid/ready idling on both sides. Depends on adst_pkg.

module advection_diffusion_stencil_tb;

  localparam int ClkPeriod = 10;
  localparam longint LimitNs = 64'd5_000_000;
  localparam int HoldCycles = 300;
  localparam int CellsPerPhase = 100;

  // Index past the last register; the block must ignore writes to it
  localparam logic [2:0] CfgSpare = 3'd5;

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;

  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QLsb = 32'sh0000_0001;
  localparam logic signed [31:0] QNeg = 32'shffff_ffff;
  localparam logic signed [31:0] QZero = 32'sh0000_0000;
  // Half span of "physical" velocities: +/-8.0
  localparam int SmallSpan = 524288;

  typedef enum int {IdleRecvHeavy, IdleSendHeavy, IdleNone} idle_mode_e;
  typedef enum int {WordFull, WordSmall, WordEdge} word_kind_e;
  typedef enum int {RegPlain, RegTop, RegZero, RegAny, RegMixed} reg_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [2:0]          cfg_idx_i;
  logic [30:0]         cfg_wdata_i;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  adst_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  adst_pkg::out_item_t out_item_o;

  advection_diffusion_stencil i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow copy of the coefficient registers, kept in sync by write_reg
  longint nu_q = adst_pkg::CfgReset;
  longint kx_q = adst_pkg::CfgReset;
  longint ky_q = adst_pkg::CfgReset;
  longint kxx_q = adst_pkg::CfgReset;
  longint kyy_q = adst_pkg::CfgReset;

  adst_pkg::in_item_t  cell_backlog[$];   // cells waiting to be offered
  adst_pkg::out_item_t rhs_expected[$];   // predicted rhs, oldest first
  adst_pkg::out_item_t want;

  int          cells_queued = 0;
  int          cells_accepted = 0;
  int          rhs_checked = 0;
  int          mismatches = 0;
  bit          in_fire = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor. All arithmetic is done exactly in 64 bits, then
  // clamped to the signed 32-bit range at the same points as the hardware.
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint x);
    if (x > WordMax) return WordMax;
    if (x < WordMin) return WordMin;
    return x;
  endfunction

  // Q16.16 multiply: floor of the shifted product, clamped
  function automatic longint scale_q(input longint a, input longint b);
    return clamp32((a * b) >>> adst_pkg::FracBits);
  endfunction

  // Face value: floor((a + b) / 2), always fits
  function automatic longint face(input longint a, input longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint flux_gap(input longint p, input longint q,
                                      input longint r, input longint s);
    return clamp32(scale_q(p, q) - scale_q(r, s));
  endfunction

  function automatic longint curvature(input longint a, input longint c, input longint b);
    return clamp32(a - 2 * c + b);
  endfunction

  function automatic adst_pkg::out_item_t predict_rhs(input adst_pkg::in_item_t c);
    longint uc, ue, uw, un, us, vc, ve, vw, vn, vs;
    longint fue, fuw, fun, fus, fve, fvw, fvn, fvs;
    longint adv, crs, dif, rx, ry;
    adst_pkg::out_item_t r;
    uc = c.u_center; ue = c.u_east; uw = c.u_west; un = c.u_north; us = c.u_south;
    vc = c.v_center; ve = c.v_east; vw = c.v_west; vn = c.v_north; vs = c.v_south;
    fue = face(ue, uc); fuw = face(uc, uw); fun = face(un, uc); fus = face(uc, us);
    fve = face(ve, vc); fvw = face(vc, vw); fvn = face(vn, vc); fvs = face(vc, vs);

    // x momentum: d(uu)/dx + d(uv)/dy against viscous smoothing of u
    adv = scale_q(flux_gap(fue, fue, fuw, fuw), kx_q);
    crs = scale_q(flux_gap(fun, fvn, fus, fvs), ky_q);
    dif = clamp32(scale_q(curvature(ue, uc, uw), kxx_q) +
                  scale_q(curvature(un, uc, us), kyy_q));
    rx = clamp32(-adv - crs + scale_q(nu_q, dif));

    // y momentum: d(vv)/dy + d(uv)/dx against viscous smoothing of v
    adv = scale_q(flux_gap(fvn, fvn, fvs, fvs), ky_q);
    crs = scale_q(flux_gap(fue, fve, fuw, fvw), kx_q);
    dif = clamp32(scale_q(curvature(ve, vc, vw), kxx_q) +
                  scale_q(curvature(vn, vc, vs), kyy_q));
    ry = clamp32(-adv - crs + scale_q(nu_q, dif));

    r.rhs_x = rx[31:0];
    r.rhs_y = ry[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic adst_pkg::in_item_t make_cell(input logic signed [31:0] uc, ue, uw,
                                                   input logic signed [31:0] un, us,
                                                   input logic signed [31:0] vc, ve, vw,
                                                   input logic signed [31:0] vn, vs);
    adst_pkg::in_item_t c;
    c.u_center = uc; c.u_east = ue; c.u_west = uw; c.u_north = un; c.u_south = us;
    c.v_center = vc; c.v_east = ve; c.v_west = vw; c.v_north = vn; c.v_south = vs;
    return c;
  endfunction

  function automatic logic signed [31:0] pick_word(input word_kind_e kind);
    logic signed [31:0] w;
    case (kind)
      WordFull:  w = $urandom;
      WordSmall: w = int'($urandom_range(2 * SmallSpan)) - SmallSpan;
      default: begin
        case ($urandom_range(4))
          0:       w = QMax;
          1:       w = QMin;
          2:       w = QZero;
          3:       w = QNeg;
          default: w = QLsb;
        endcase
      end
    endcase
    return w;
  endfunction

  // Small neighbor offset, +/-0.5
  function automatic logic signed [31:0] nudge();
    return int'($urandom_range(65536)) - 32768;
  endfunction

  function automatic adst_pkg::in_item_t rand_cell();
    adst_pkg::in_item_t c;
    logic signed [31:0] uc, vc;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // smooth flow: neighbors close to the center value
        uc = pick_word(WordSmall);
        vc = pick_word(WordSmall);
        c = make_cell(uc, uc + nudge(), uc + nudge(), uc + nudge(), uc + nudge(),
                      vc, vc + nudge(), vc + nudge(), vc + nudge(), vc + nudge());
      end
      4, 5:
        for (int i = 0; i < 10; i++) c[i*32 +: 32] = pick_word(WordSmall);
      6, 7:
        for (int i = 0; i < 10; i++) c[i*32 +: 32] = pick_word(WordFull);
      8:
        for (int i = 0; i < 10; i++) c[i*32 +: 32] = pick_word(word_kind_e'($urandom_range(2)));
      default:
        for (int i = 0; i < 10; i++) c[i*32 +: 32] = pick_word(WordEdge);
    endcase
    return c;
  endfunction

  function automatic logic [30:0] pick_reg(input reg_kind_e kind);
    logic [30:0] r;
    reg_kind_e k;
    k = kind;
    if (k == RegMixed) k = reg_kind_e'($urandom_range(3));
    case (k)
      RegPlain: r = 31'($urandom_range(32'h0010_0000, 32'h0000_1000)); // roughly 1/16 .. 16
      RegTop:   r = 31'h7fff_ffff;
      RegZero:  r = 31'h0;
      default:  r = 31'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Called at a falling edge; leaves the write enable high for the caller to drop
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      adst_pkg::CfgViscosity: nu_q = val;
      adst_pkg::CfgInvDxX:    kx_q = val;
      adst_pkg::CfgInvDxY:    ky_q = val;
      adst_pkg::CfgInvDxXSq:  kxx_q = val;
      adst_pkg::CfgInvDxYSq:  kyy_q = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input reg_kind_e kind);
    write_reg(adst_pkg::CfgViscosity, pick_reg(kind));
    write_reg(adst_pkg::CfgInvDxX, pick_reg(kind));
    write_reg(adst_pkg::CfgInvDxY, pick_reg(kind));
    write_reg(adst_pkg::CfgInvDxXSq, pick_reg(kind));
    write_reg(adst_pkg::CfgInvDxYSq, pick_reg(kind));
    write_reg(CfgSpare, 31'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IdleRecvHeavy: begin send_idle_pct = 21; recv_idle_pct = 79; end
      IdleSendHeavy: begin send_idle_pct = 79; recv_idle_pct = 21; end
      default:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  task automatic queue_cell(input adst_pkg::in_item_t c);
    cell_backlog.push_back(c);
    cells_queued++;
  endtask

  // Block until every queued cell went in and every rhs came back
  task automatic drain();
    while (cells_accepted != cells_queued || rhs_expected.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers cells from the backlog at the falling edge. A cell stays
  // on the bus until the rising edge that takes it; only then may the sender
  // idle or present the next one.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (cell_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i <= cell_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off while it is counting down
  always @(negedge clk_i) begin
    out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold-off counter: fires once when armed and lets the pipeline back up
  always @(posedge clk_i) begin
    if (hold_armed && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted cell, checks every accepted rhs
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        rhs_expected.push_back(predict_rhs(in_item_i));
        cells_accepted++;
      end
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (rhs_expected.size() == 0) begin
          report_mismatch($sformatf("rhs %h with no cell outstanding", out_item_o));
        end else begin
          want = rhs_expected.pop_front();
          if (out_item_o.rhs_x !== want.rhs_x)
            report_mismatch($sformatf("rhs #%0d rhs_x got %h want %h",
                                      rhs_checked, out_item_o.rhs_x, want.rhs_x));
          if (out_item_o.rhs_y !== want.rhs_y)
            report_mismatch($sformatf("rhs #%0d rhs_y got %h want %h",
                                      rhs_checked, out_item_o.rhs_y, want.rhs_y));
          rhs_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed cells under reset coefficients, then random phases,
  // each with its own coefficient set and idling pattern.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = adst_pkg::CfgViscosity;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_idling(IdleRecvHeavy);
    // zero field, and each extreme everywhere
    queue_cell(make_cell(QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero, QZero));
    queue_cell(make_cell(QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax));
    queue_cell(make_cell(QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin));
    // spike and pit: second differences clamp both ways
    queue_cell(make_cell(QMax, QMin, QMin, QMin, QMin, QMax, QMin, QMin, QMin, QMin));
    queue_cell(make_cell(QMin, QMax, QMax, QMax, QMax, QMin, QMax, QMax, QMax, QMax));
    // steep opposite gradients: face squares and cross terms clamp
    queue_cell(make_cell(QZero, QMax, QMin, QMin, QMax, QZero, QMin, QMax, QMax, QMin));
    queue_cell(make_cell(QMax, QMax, QZero, QMax, QZero, QMin, QMin, QZero, QMin, QZero));
    queue_cell(make_cell(QMin, QMax, QMax, QMin, QMin, QMax, QMin, QMin, QMax, QMax));
    // uniform unit flow: no advection, no diffusion
    queue_cell(make_cell(QOne, QOne, QOne, QOne, QOne, QOne, QOne, QOne, QOne, QOne));
    // linear ramps
    queue_cell(make_cell(QOne, 2 * QOne, QZero, 3 * QOne, -QOne,
                         -QOne, QZero, -2 * QOne, 2 * QOne, -4 * QOne));
    // odd face sums: halving rounds toward minus infinity
    queue_cell(make_cell(QLsb, QZero, QZero, QZero, QZero, QNeg, QZero, QZero, QZero, QZero));
    queue_cell(make_cell(QNeg, QZero, QLsb, QNeg, QLsb, QLsb, QNeg, QZero, QLsb, QNeg));
    // tiny negative products: fraction drop rounds toward minus infinity
    queue_cell(make_cell(QNeg, QNeg, QNeg, QNeg, QNeg, QLsb, QLsb, QLsb, QLsb, QLsb));
    queue_cell(make_cell(QNeg, QLsb, QNeg, QLsb, QNeg, QLsb, QNeg, QLsb, QNeg, QLsb));
    // u at one rail, v at the other
    queue_cell(make_cell(QMax, QMax, QMax, QMax, QMax, QMin, QMin, QMin, QMin, QMin));
    queue_cell(make_cell(QMin, QMax, QMin, QMax, QMin, QMax, QMin, QMax, QMin, QMax));
    for (int i = 0; i < 6; i++) queue_cell(rand_cell());
    drain();

    // random phases; the extreme coefficient sets come early
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_config(RegPlain);
        1: set_config(RegTop);
        2: set_config(RegZero);
        3: set_config(RegMixed);
        4: set_config(RegPlain);
        5: set_config(RegAny);
        default: set_config(RegMixed);
      endcase
      if (phase < 2) set_idling(IdleRecvHeavy);
      else if (phase < 4) set_idling(IdleSendHeavy);
      else set_idling(IdleNone);
      // long receiver hold-off with the sender running flat out
      if (phase == 4) hold_armed = 1'b1;
      for (int i = 0; i < CellsPerPhase; i++) queue_cell(rand_cell());
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && rhs_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitNs);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/adst_pkg.sv
sv/adst_prep.sv
sv/adst_mul1.sv
sv/adst_reduce.sv
sv/adst_post.sv
sv/advection_diffusion_stencil.sv
tb/advection_diffusion_stencil_tb.sv
